// ===== rtl/two_channel_moving_average_assert.svh =====
// Assertion macros for the moving-average block.
// Both sample on the rising edge of clk_i and are held off while rst_ni is low.
`ifndef TWO_CHANNEL_MOVING_AVERAGE_ASSERT_SVH
`define TWO_CHANNEL_MOVING_AVERAGE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCMA_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("tcma: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCMA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("tcma: next-cycle check failed");

`endif

// ===== rtl/tcma_pkg.sv =====
package tcma_pkg;

  localparam int SampleW      = 16;
  localparam int SumOutW      = 23;
  localparam int AvgW         = 24;
  localparam int MTdataW      = 48;  // window_sum + average_q8, padded to whole bytes
  localparam int WindowDef    = 100;
  localparam int ChannelsDef  = 2;
  // Half range of a sample; sums are offset by WINDOW times this before division.
  localparam int SampleHalf   = 32768;
  // The offset above, scaled by 256/WINDOW, taken back out of the quotient.
  localparam int AvgBias      = 1 << 23;

  // Width of a channel index into per-channel arrays.
  function automatic int ch_idx_w(input int channels);
    return (channels > 1) ? $clog2(channels) : 1;
  endfunction

  // Width of an exact window sum for a given window length.
  function automatic int sum_w(input int window);
    return SampleW + $clog2(window);
  endfunction

endpackage

// ===== rtl/two_channel_moving_average.sv =====
// Two-channel moving average over the last WINDOW samples of each channel.
//
// Input stream: s_axis_tdata carries one signed 16-bit sample, s_axis_tuser
// the channel it belongs to. Each accepted transaction overwrites the oldest
// entry of that channel's ring in the sample memory and yields exactly one
// output transaction: the updated window sum and floor(sum * 256 / WINDOW),
// the window average in signed Q.8. A channel index at or above CHANNELS is
// accepted and dropped without effect.
//
// Throughput is one transaction per cycle while the receiver does not stall.
// The ring memory is read as a sample enters stage A and written back as it
// leaves; the average then passes reciprocal-multiply divider stages B, C
// and D and output register E, which drives m_axis_tvalid.
//
// Reset clears pointers, running sums and pipeline valids at once. Ring
// entries not yet written since reset read as zero, tracked by one wrap flag
// per channel, so there is no clearing pass. When the receiver stalls, the
// pipeline fills its empty stages and then deasserts s_axis_tready.
module two_channel_moving_average #(
  parameter int WINDOW   = tcma_pkg::WindowDef,
  parameter int CHANNELS = tcma_pkg::ChannelsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tcma_pkg::SampleW-1:0]  s_axis_tdata,  // [15:0] sample
  input  logic                          s_axis_tuser,  // [0] channel
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tcma_pkg::MTdataW-1:0]  m_axis_tdata,  // [22:0] window_sum, [46:23] average_q8
  output logic                          m_axis_tuser   // [0] channel_out
);
  import tcma_pkg::*;

  localparam int SUM_W = sum_w(WINDOW);

  logic                    ring_valid;
  logic                    ring_ready;
  logic                    ring_ch;
  logic signed [SUM_W-1:0] ring_sum;
  logic [SumOutW-1:0]      out_sum;
  logic [AvgW-1:0]         out_avg;
  logic                    ch_ok;

  // Sample memory, pointers and running sums; one read-modify-write per sample.
  tcma_ring #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_ch_i     (s_axis_tuser),
    .in_sample_i ($signed(s_axis_tdata)),
    .out_valid_o (ring_valid),
    .out_ready_i (ring_ready),
    .out_ch_o    (ring_ch),
    .out_sum_o   (ring_sum)
  );

  // Divide the sum by WINDOW in Q.8 and hold the result for the receiver.
  tcma_div #(
    .WINDOW (WINDOW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ring_valid),
    .in_ready_o  (ring_ready),
    .in_ch_i     (ring_ch),
    .in_sum_i    (ring_sum),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ch_o    (m_axis_tuser),
    .out_sum_o   (out_sum),
    .out_avg_o   (out_avg)
  );

  assign m_axis_tdata = {1'b0, out_avg, out_sum};
  assign ch_ok        = (32'(s_axis_tuser) < CHANNELS);

`include "two_channel_moving_average_assert.svh"

  // A sample of a present channel enters the read-modify-write stage.
  `TCMA_ASSERT_NEXT(a_take_loads_ring, s_axis_tvalid && s_axis_tready && ch_ok, ring_valid)
  // With the output register empty, every stage can move, so the input is ready.
  `TCMA_ASSERT_NOW(a_empty_out_ready, !m_axis_tvalid, s_axis_tready)
  // A floored average carries the sign of its sum (sum field exact up to 128).
  `TCMA_ASSERT_NOW(a_avg_sign, m_axis_tvalid, (WINDOW > 128) || (m_axis_tdata[46] == m_axis_tdata[22]))

endmodule

// ===== rtl/tcma_ring.sv =====
module tcma_ring #(
  parameter int WINDOW   = tcma_pkg::WindowDef,
  parameter int CHANNELS = tcma_pkg::ChannelsDef
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic                                       in_ch_i,
  input  logic signed [tcma_pkg::SampleW-1:0]        in_sample_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic                                       out_ch_o,
  output logic signed [tcma_pkg::sum_w(WINDOW)-1:0]  out_sum_o
);
  import tcma_pkg::*;

  localparam int CH_W   = ch_idx_w(CHANNELS);
  localparam int PTR_W  = $clog2(WINDOW);
  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = sum_w(WINDOW);

  logic [SampleW-1:0]      mem [DEPTH];
  logic [SampleW-1:0]      rdata_q;

  logic [PTR_W-1:0]        ptr_q  [CHANNELS];
  logic                    full_q [CHANNELS];
  logic signed [SUM_W-1:0] sum_q  [CHANNELS];

  logic                    a_valid_q;
  logic                    a_ch_q;
  logic signed [SampleW-1:0] a_sample_q;
  logic [ADDR_W-1:0]       a_addr_q;
  logic                    a_full_q;

  logic [CH_W-1:0]         in_idx;
  logic [CH_W-1:0]         a_idx;
  logic                    ch_ok;
  logic                    take;
  logic                    retire;
  logic [ADDR_W-1:0]       raddr;
  logic                    wrap;
  logic signed [SUM_W-1:0] evicted;
  logic signed [SUM_W-1:0] new_sum;

  assign in_idx     = CH_W'(in_ch_i);
  assign a_idx      = CH_W'(a_ch_q);
  assign ch_ok      = (32'(in_ch_i) < CHANNELS);
  assign in_ready_o = !a_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o && ch_ok;
  assign retire     = a_valid_q && out_ready_i;
  assign raddr      = ADDR_W'(32'(in_idx) * WINDOW + 32'(ptr_q[in_idx]));
  assign wrap       = (32'(ptr_q[in_idx]) == WINDOW - 1);

  // Entries of a ring that has not yet wrapped were never written: they read as zero.
  assign evicted = a_full_q ? SUM_W'($signed(rdata_q)) : '0;
  assign new_sum = sum_q[a_idx] + SUM_W'(a_sample_q) - evicted;

  assign out_valid_o = a_valid_q;
  assign out_ch_o    = a_ch_q;
  assign out_sum_o   = new_sum;

  always_ff @(posedge clk_i) begin
    if (retire) begin
      mem[a_addr_q] <= a_sample_q;
    end
    if (take) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_ch_q     <= in_ch_i;
      a_sample_q <= in_sample_i;
      a_addr_q   <= raddr;
      a_full_q   <= full_q[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        ptr_q[c]  <= '0;
        full_q[c] <= 1'b0;
        sum_q[c]  <= '0;
      end
    end else begin
      if (take) begin
        a_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        a_valid_q <= 1'b0;
      end
      if (take) begin
        ptr_q[in_idx] <= wrap ? '0 : ptr_q[in_idx] + PTR_W'(1);
        if (wrap) begin
          full_q[in_idx] <= 1'b1;
        end
      end
      if (retire) begin
        sum_q[a_idx] <= new_sum;
      end
    end
  end

endmodule

// ===== rtl/tcma_div.sv =====
module tcma_div #(
  parameter int WINDOW = tcma_pkg::WindowDef
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic                                       in_ch_i,
  input  logic signed [tcma_pkg::sum_w(WINDOW)-1:0]  in_sum_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic                                       out_ch_o,
  output logic [tcma_pkg::SumOutW-1:0]               out_sum_o,
  output logic [tcma_pkg::AvgW-1:0]                  out_avg_o
);
  import tcma_pkg::*;

  localparam int SUM_W = sum_w(WINDOW);
  localparam int K     = SUM_W + 8;
  localparam int M_W   = K - $clog2(WINDOW) + 1;
  localparam logic [M_W-1:0]   RECIP = M_W'((64'd1 << K) / WINDOW);
  localparam logic [SUM_W-1:0] BIAS  = SUM_W'(WINDOW * SampleHalf);

  // Stage B: offset sum
  logic                    b_valid_q, b_ch_q;
  logic signed [SUM_W-1:0] b_sum_q;
  logic [SUM_W-1:0]        b_u_q;
  // Stage C: estimated quotient
  logic                    c_valid_q, c_ch_q;
  logic signed [SUM_W-1:0] c_sum_q;
  logic [SUM_W-1:0]        c_u_q;
  logic [M_W-1:0]          c_q0_q;
  // Stage D: back-multiplied estimate
  logic                    d_valid_q, d_ch_q;
  logic signed [SUM_W-1:0] d_sum_q;
  logic [SUM_W-1:0]        d_u_q;
  logic [M_W-1:0]          d_q0_q;
  logic [K-1:0]            d_p_q;
  // Stage E: output register
  logic                    e_valid_q, e_ch_q;
  logic [SumOutW-1:0]      e_sum_q;
  logic [AvgW-1:0]         e_avg_q;

  logic b_rdy, c_rdy, d_rdy, e_rdy;
  logic [SUM_W+M_W-1:0]    prod;
  logic [K-1:0]            rem;
  logic [M_W-1:0]          quot;

  assign e_rdy      = !e_valid_q || out_ready_i;
  assign d_rdy      = !d_valid_q || e_rdy;
  assign c_rdy      = !c_valid_q || d_rdy;
  assign b_rdy      = !b_valid_q || c_rdy;
  assign in_ready_o = b_rdy;

  assign prod = (SUM_W+M_W)'(b_u_q) * (SUM_W+M_W)'(RECIP);
  // Estimate is exact or one low; one compare settles it.
  assign rem  = {d_u_q, 8'd0} - d_p_q;
  assign quot = d_q0_q + M_W'(32'(rem) >= WINDOW);

  always_ff @(posedge clk_i) begin
    if (b_rdy) begin
      b_ch_q  <= in_ch_i;
      b_sum_q <= in_sum_i;
      b_u_q   <= SUM_W'($unsigned(in_sum_i) + BIAS);
    end
    if (c_rdy) begin
      c_ch_q  <= b_ch_q;
      c_sum_q <= b_sum_q;
      c_u_q   <= b_u_q;
      c_q0_q  <= prod[SUM_W +: M_W];
    end
    if (d_rdy) begin
      d_ch_q  <= c_ch_q;
      d_sum_q <= c_sum_q;
      d_u_q   <= c_u_q;
      d_q0_q  <= c_q0_q;
      d_p_q   <= K'(64'(c_q0_q) * 64'(WINDOW));
    end
    if (e_rdy) begin
      e_ch_q  <= d_ch_q;
      e_sum_q <= SumOutW'(d_sum_q);
      e_avg_q <= AvgW'(quot - M_W'(AvgBias));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else begin
      if (b_rdy) b_valid_q <= in_valid_i;
      if (c_rdy) c_valid_q <= b_valid_q;
      if (d_rdy) d_valid_q <= c_valid_q;
      if (e_rdy) e_valid_q <= d_valid_q;
    end
  end

  assign out_valid_o = e_valid_q;
  assign out_ch_o    = e_ch_q;
  assign out_sum_o   = e_sum_q;
  assign out_avg_o   = e_avg_q;

endmodule

// ===== tb/tb_two_channel_moving_average.sv =====
`timescale 1ns / 1ps

module tb_two_channel_moving_average;

  localparam int WinLen      = tcma_pkg::WindowDef;
  localparam int QuietLimit  = 2000;  // cycles with no transaction on either side
  localparam int TailCycles  = 20;    // well past the pipeline, stages A to E
  localparam int HoldAt      = 250;   // result count that triggers the long hold-off
  localparam int HoldCycles  = 120;
  localparam int RailLen     = 205;   // enough to flush both rings with one value
  localparam int RandomItems = 600;

  typedef enum logic [1:0] {
    MIX_UNIFORM,
    MIX_SMALL,
    MIX_ONE_CH,
    MIX_RAIL
  } sample_mix_e;

  typedef struct {
    bit          ch;
    logic [15:0] smp;
    bit          typed;
    int          sum;
    int          avg;
  } dir_row_t;

  typedef struct {
    bit          ch;
    logic [22:0] sum;
    logic [23:0] avg;
  } window_result_t;

  // Hand-checked rows carry the expected window; the rest go to the predictor.
  dir_row_t dir_rows [18] = '{
    '{1'b0, 16'h0000, 1'b1,    0,    0},  // untouched ring reads as zero
    '{1'b1, 16'h0000, 1'b1,    0,    0},
    '{1'b0, 16'h0064, 1'b1,  100,  256},  // +100
    '{1'b1, 16'hFF9C, 1'b1, -100, -256},  // -100, exact quotient
    '{1'b1, 16'hFFFF, 1'b1, -101, -259},  // negative quotient rounds down
    '{1'b0, 16'h0001, 1'b1,  101,  258},
    '{1'b0, 16'h7FFF, 1'b0,    0,    0},
    '{1'b1, 16'h8000, 1'b0,    0,    0},
    '{1'b0, 16'h8000, 1'b0,    0,    0},
    '{1'b1, 16'h7FFF, 1'b0,    0,    0},
    '{1'b0, 16'h5555, 1'b0,    0,    0},
    '{1'b1, 16'hAAAA, 1'b0,    0,    0},
    '{1'b0, 16'hFFFF, 1'b0,    0,    0},
    '{1'b1, 16'h0001, 1'b0,    0,    0},
    '{1'b0, 16'h8001, 1'b0,    0,    0},
    '{1'b1, 16'h7FFE, 1'b0,    0,    0},
    '{1'b0, 16'h0080, 1'b0,    0,    0},
    '{1'b1, 16'hFF80, 1'b0,    0,    0}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [tcma_pkg::SampleW-1:0] s_axis_tdata;   // [15:0] sample
  logic                         s_axis_tuser;   // [0] channel
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [tcma_pkg::MTdataW-1:0] m_axis_tdata;   // [22:0] window_sum, [46:23] average_q8
  logic                         m_axis_tuser;   // [0] channel_out

  two_channel_moving_average uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow copy of both channels' rings, pointers and sums.
  logic signed [15:0] shadow_ring [2][WinLen];
  int unsigned        shadow_ptr  [2];
  int                 shadow_sum  [2];

  window_result_t pending_windows [$];

  // Row-typed expectation for the transaction currently offered.
  bit          cur_typed;
  int          cur_sum;
  int          cur_avg;

  int          err_cnt;
  int          quiet_cycles;
  int          samples_in;
  int          results_out;
  int          rail_hits;
  window_result_t predicted;
  window_result_t oldest;

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [23:0] q8_floor_avg(input int sum);
    longint num;
    longint quo;
    num = longint'(sum) * 256;
    quo = num / WinLen;
    // Round toward minus infinity, not toward zero.
    if ((num % WinLen) != 0 && num < 0) quo = quo - 1;
    return quo[23:0];
  endfunction

  // Push one sample into the shadow ring and return the updated window.
  function automatic window_result_t advance_window(input bit ch, input logic [15:0] smp);
    window_result_t res;
    int unsigned    p;
    int             evicted;
    p = shadow_ptr[ch];
    evicted = int'(shadow_ring[ch][p]);
    shadow_ring[ch][p] = smp;
    shadow_sum[ch] = shadow_sum[ch] + int'($signed(smp)) - evicted;
    shadow_ptr[ch] = (p == WinLen - 1) ? 0 : p + 1;
    res.ch  = ch;
    res.sum = shadow_sum[ch][22:0];
    res.avg = q8_floor_avg(shadow_sum[ch]);
    return res;
  endfunction

  // Predict on input transactions, check on output transactions, track quiet time.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = advance_window(s_axis_tuser, s_axis_tdata);
        if (cur_typed) begin
          predicted.sum = cur_sum[22:0];
          predicted.avg = cur_avg[23:0];
        end
        pending_windows.push_back(predicted);
        samples_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_out++;
        if (m_axis_tdata[22:0] == 23'h4E0000 || m_axis_tdata[22:0] == 23'h31FF9C)
          rail_hits++;
        if (pending_windows.size() == 0) begin
          $error("unexpected result on channel %0d, nothing pending", m_axis_tuser);
          err_cnt++;
        end else begin
          oldest = pending_windows.pop_front();
          if (m_axis_tuser !== oldest.ch) begin
            $error("channel_out mismatch: expected %0d, got %0d", oldest.ch, m_axis_tuser);
            err_cnt++;
          end
          if (m_axis_tdata[22:0] !== oldest.sum) begin
            $error("window_sum mismatch: expected %0d, got %0d",
                   $signed(oldest.sum), $signed(m_axis_tdata[22:0]));
            err_cnt++;
          end
          if (m_axis_tdata[46:23] !== oldest.avg) begin
            $error("average_q8 mismatch: expected %0d, got %0d",
                   $signed(oldest.avg), $signed(m_axis_tdata[46:23]));
            err_cnt++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // Abort when the block stops moving transactions.
  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("timeout: no transaction for %0d cycles", QuietLimit);
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: stall a random number of cycles after each result, sometimes not at all,
  // and hold off once for a long stretch so the pipeline fills and backs up the input.
  initial begin : sink
    int  stall;
    int  taken;
    bit  eager;
    stall = 0;
    taken = 0;
    eager = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        taken++;
        if (taken % 40 == 0) eager = ($urandom_range(0, 2) == 0);
        stall = eager ? 0 : $urandom_range(0, 12);
        if (taken == HoldAt) stall = HoldCycles;
      end
    end
  end

  // If gap is nonzero, idle first; then offer one sample and hold it until taken.
  task automatic send_sample(input bit ch, input logic [15:0] smp, input int gap,
                             input bit typed, input int sum, input int avg);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cur_typed = typed;
    cur_sum   = sum;
    cur_avg   = avg;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drive len random samples of one flavor; flip swaps the rail polarity per channel.
  task automatic run_segment(input sample_mix_e mix, input int len, input bit flip);
    bit          eager;
    bit          solo_ch;
    bit          ch;
    logic [15:0] smp;
    eager   = ($urandom_range(0, 3) == 0);
    solo_ch = 1'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      ch  = 1'($urandom_range(0, 1));
      smp = 16'($urandom_range(0, 16'hFFFF));
      case (mix)
        MIX_SMALL: begin
          smp = 16'(int'($urandom_range(0, 8)) - 4);
        end
        MIX_ONE_CH: begin
          ch = solo_ch;
        end
        MIX_RAIL: begin
          // Alternate channels so both rings fill with full-scale values.
          ch  = i[0];
          smp = (ch ^ flip) ? 16'h7FFF : 16'h8000;
        end
        default: ;
      endcase
      send_sample(ch, smp, eager ? 0 : $urandom_range(0, 12), 1'b0, 0, 0);
    end
  endtask

  task automatic run_mixed(input int count);
    int len;
    int done;
    done = 0;
    while (done < count) begin
      len = $urandom_range(20, 60);
      if (len > count - done) len = count - done;
      run_segment(sample_mix_e'($urandom_range(0, 2)), len, 1'b0);
      done += len;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cur_typed     = 1'b0;
    cur_sum       = 0;
    cur_avg       = 0;
    err_cnt       = 0;
    quiet_cycles  = 0;
    samples_in    = 0;
    results_out   = 0;
    rail_hits     = 0;
    foreach (shadow_ring[c, k]) shadow_ring[c][k] = '0;
    foreach (shadow_ptr[c]) begin
      shadow_ptr[c] = 0;
      shadow_sum[c] = 0;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed rows, back to back first, then with random gaps.
    foreach (dir_rows[r])
      send_sample(dir_rows[r].ch, dir_rows[r].smp, (r < 6) ? 0 : $urandom_range(0, 12),
                  dir_rows[r].typed, dir_rows[r].sum, dir_rows[r].avg);

    // Random part: mixed traffic around two full-scale rails of opposite polarity.
    run_mixed(100);
    run_segment(MIX_RAIL, RailLen, 1'b0);
    run_mixed(50);
    run_segment(MIX_RAIL, RailLen, 1'b1);
    run_mixed(RandomItems - 100 - 50 - 2 * RailLen);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    cur_typed = 1'b0;

    // Drain, then let the pipeline settle to catch any stray result.
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (pending_windows.size() != 0) begin
      $error("%0d results never arrived", pending_windows.size());
      err_cnt++;
    end

    $display("Sent %0d samples (%0d directed) over both channels, checked %0d windows.",
             samples_in, $size(dir_rows), results_out);
    $display("Full-scale windows seen: %0d; long receiver hold-off applied once.", rail_hits);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== two_channel_moving_average.f =====
+incdir+rtl
rtl/tcma_pkg.sv
rtl/tcma_ring.sv
rtl/tcma_div.sv
rtl/two_channel_moving_average.sv
tb/tb_two_channel_moving_average.sv
